// ===== design/etx_neighbor_parent_select_assert.svh =====
// Assertion macros shared by the checker of the neighbour table block.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ETX_NEIGHBOR_PARENT_SELECT_ASSERT_SVH
`define ETX_NEIGHBOR_PARENT_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ETXNPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("etxnps: assertion failed");

// Next-cycle implication, disabled during reset.
`define ETXNPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("etxnps: assertion failed");

`endif

// ===== design/etxnps_pkg.sv =====
// Package for the neighbour table and parent selection block.
// Holds table sizes, codes, item and job structs; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package etxnps_pkg;

    localparam int NEIGHBORS   = 16;
    localparam int TBL_W       = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] INFINITE_RANK = 16'hFFFF;
    localparam logic [6:0]  ETX_SCALE     = 7'd100;
    // ceil(2^30 / 100): exact quotient for every dividend below 2^23.
    localparam logic [23:0] RECIP_100     = 24'd10737419;
    localparam int          RECIP_SHIFT   = 30;

    localparam logic [1:0] FUNC_REPORT = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_SELECT = 2'd2;

    localparam logic [1:0] TX_OK    = 2'd0;
    localparam logic [1:0] TX_NOACK = 2'd1;

    localparam logic [2:0] REG_LINK_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_ETX_UNIT           = 3'd1;
    localparam logic [2:0] REG_NORMAL_WEIGHT      = 3'd2;
    localparam logic [2:0] REG_EARLY_WEIGHT       = 3'd3;
    localparam logic [2:0] REG_EARLY_REPORT_LIMIT = 3'd4;
    localparam logic [2:0] REG_NOACK_PENALTY      = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  entry_index;
        logic [1:0]  tx_status;
        logic [4:0]  attempts;
        logic [15:0] new_rank;
        logic [15:0] new_link_etx;
        logic        new_valid;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  parent_index;
        logic [15:0] link_etx_out;
        logic [15:0] rank_out;
    } out_item_t;

    typedef struct packed {
        logic [15:0] link_threshold;
        logic [10:0] etx_unit;
        logic [6:0]  normal_weight;
        logic [6:0]  early_weight;
        logic [7:0]  early_report_limit;
        logic [4:0]  noack_penalty;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        link_threshold:     16'd64,
        etx_unit:           11'd128,
        normal_weight:      7'd90,
        early_weight:       7'd70,
        early_report_limit: 8'd2,
        noack_penalty:      5'd16
    };

    typedef enum logic [2:0] {
        KIND_REPORT = 3'd0,
        KIND_IGNORE = 3'd1,
        KIND_WRITE  = 3'd2,
        KIND_SELECT = 3'd3,
        KIND_NONE   = 3'd4
    } kind_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        kind_t       kind;
        logic        in_table;
        logic [3:0]  entry_index;
        logic        noack;
        logic [4:0]  attempts;
        logic [15:0] new_rank;
        logic [15:0] new_link_etx;
        logic        new_valid;
    } job_t;

endpackage

`default_nettype wire

// ===== design/etx_neighbor_parent_select.sv =====
// Top level of the neighbour table and parent selection block.
// Holds the configuration registers; uses etxnps_pkg, etxnps_front, etxnps_fifo, etxnps_back.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a table of neighbour entries (present flag, link ETX, rank and
// report count) and answers every input item with exactly one result item. A
// write item loads an entry, a transmit report folds the frame's ETX into the
// entry by a percent moving average, and a select item scans the table for the
// preferred parent. A front end classifies items and places them in a two-entry
// queue, so the input side keeps accepting items while the queue has room, also
// while the table engine works or a result waits to be taken. The engine handles
// one item at a time: a write, an ignored report or an unused code goes straight
// to the result, a transmit report is read, weighted with its packet ETX, blended,
// scaled by the reciprocal of one hundred and stored, and a select sweeps the
// table once for the best link and once more for the lowest rank within the
// margin, because the table has one read port. Of the table, only the present
// flags are cleared by reset, so the block is ready straight out of reset with
// no clearing pass. Configuration is written over the APB port at byte address
// four times the register index; the user must do so only while the block is idle, unchecked.

module etx_neighbor_parent_select (
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   s_valid,
    output logic                  s_ready,
    input  etxnps_pkg::in_item_t  s_data,

    output logic                  m_valid,
    input  wire                   m_ready,
    output etxnps_pkg::out_item_t m_data,

    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [4:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    etxnps_pkg::cfg_t cfg_reg, cfg_next;
    logic             cfg_write;

    logic             q_full, q_empty, q_push, q_pop;
    etxnps_pkg::job_t q_job, q_head;

    // The register is written on the access phase of an APB write; there are
    // no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (paddr[4:2])
                etxnps_pkg::REG_LINK_THRESHOLD:     cfg_next.link_threshold = pwdata[15:0];
                etxnps_pkg::REG_ETX_UNIT:           cfg_next.etx_unit = pwdata[10:0];
                etxnps_pkg::REG_NORMAL_WEIGHT:      cfg_next.normal_weight = pwdata[6:0];
                etxnps_pkg::REG_EARLY_WEIGHT:       cfg_next.early_weight = pwdata[6:0];
                etxnps_pkg::REG_EARLY_REPORT_LIMIT: cfg_next.early_report_limit = pwdata[7:0];
                etxnps_pkg::REG_NOACK_PENALTY:      cfg_next.noack_penalty = pwdata[4:0];
                default: begin
                    // Addresses beyond the register list are ignored.
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            etxnps_pkg::REG_LINK_THRESHOLD:     prdata = {16'd0, cfg_reg.link_threshold};
            etxnps_pkg::REG_ETX_UNIT:           prdata = {21'd0, cfg_reg.etx_unit};
            etxnps_pkg::REG_NORMAL_WEIGHT:      prdata = {25'd0, cfg_reg.normal_weight};
            etxnps_pkg::REG_EARLY_WEIGHT:       prdata = {25'd0, cfg_reg.early_weight};
            etxnps_pkg::REG_EARLY_REPORT_LIMIT: prdata = {24'd0, cfg_reg.early_report_limit};
            etxnps_pkg::REG_NOACK_PENALTY:      prdata = {27'd0, cfg_reg.noack_penalty};
            default:                            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= etxnps_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classification of incoming items.
    etxnps_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_job)
    );

    // Queue that decouples the input side from the table engine.
    etxnps_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Table engine with the result register.
    etxnps_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== design/etxnps_front.sv =====
// Front end: accepts input items and classifies them into jobs for the queue.
// Depends on etxnps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module etxnps_front (
    input  wire                 s_valid,
    output logic                s_ready,
    input  etxnps_pkg::in_item_t s_data,
    input  wire                 q_full,
    output logic                q_push,
    output etxnps_pkg::job_t    q_job
);

    logic in_table;

    assign in_table = (int'(s_data.entry_index) < etxnps_pkg::NEIGHBORS);
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;

    always_comb begin
        q_job.in_table     = in_table;
        q_job.entry_index  = s_data.entry_index;
        q_job.noack        = (s_data.tx_status == etxnps_pkg::TX_NOACK);
        q_job.attempts     = s_data.attempts;
        q_job.new_rank     = s_data.new_rank;
        q_job.new_link_etx = s_data.new_link_etx;
        q_job.new_valid    = s_data.new_valid;
        case (s_data.func)
            etxnps_pkg::FUNC_REPORT: begin
                // Collision and error reports, and reports beyond the table, change nothing.
                if (in_table && (s_data.tx_status inside {etxnps_pkg::TX_OK,
                                                          etxnps_pkg::TX_NOACK})) begin
                    q_job.kind = etxnps_pkg::KIND_REPORT;
                end else begin
                    q_job.kind = etxnps_pkg::KIND_IGNORE;
                end
            end
            etxnps_pkg::FUNC_WRITE:  q_job.kind = etxnps_pkg::KIND_WRITE;
            etxnps_pkg::FUNC_SELECT: q_job.kind = etxnps_pkg::KIND_SELECT;
            default:                 q_job.kind = etxnps_pkg::KIND_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/etxnps_fifo.sv =====
// Short job queue between the front end and the table engine.
// Depends on etxnps_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module etxnps_fifo (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push,
    input  etxnps_pkg::job_t          push_job,
    output logic                      full,
    input  wire                       pop,
    output logic                      empty,
    output etxnps_pkg::job_t          head
);

    etxnps_pkg::job_t                     slot_reg [etxnps_pkg::QUEUE_DEPTH];
    logic [etxnps_pkg::QUEUE_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [etxnps_pkg::QUEUE_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [etxnps_pkg::QUEUE_CW-1:0]      count_reg, count_next;
    logic                                 do_push, do_pop;

    localparam logic [etxnps_pkg::QUEUE_AW-1:0] LAST_SLOT =
        etxnps_pkg::QUEUE_AW'(etxnps_pkg::QUEUE_DEPTH - 1);
    localparam logic [etxnps_pkg::QUEUE_CW-1:0] FULL_COUNT =
        etxnps_pkg::QUEUE_CW'(etxnps_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/etxnps_back.sv =====
// Table engine: holds the neighbour table, runs ETX updates, writes and the
// two-pass parent scan, and owns the result register. Depends on etxnps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module etxnps_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  etxnps_pkg::cfg_t      cfg,
    input  wire                   q_empty,
    input  etxnps_pkg::job_t      q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire                   m_ready,
    output etxnps_pkg::out_item_t m_data
);

    localparam int TW = etxnps_pkg::TBL_W;
    localparam logic [TW-1:0] LAST_ENTRY = TW'(etxnps_pkg::NEIGHBORS - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WEIGH = 8'b0000_0010,
        ST_BLEND = 8'b0000_0100,
        ST_SCALE = 8'b0000_1000,
        ST_STORE = 8'b0001_0000,
        ST_SCAN1 = 8'b0010_0000,
        ST_SCAN2 = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic [6:0] clamp_weight(input logic [6:0] w);
        clamp_weight = (w > etxnps_pkg::ETX_SCALE) ? etxnps_pkg::ETX_SCALE : w;
    endfunction

    state_t state_reg, state_next;

    // Table storage.
    logic [15:0]                     link_mem [etxnps_pkg::NEIGHBORS];
    logic [15:0]                     rank_mem [etxnps_pkg::NEIGHBORS];
    logic [7:0]                      cnt_mem  [etxnps_pkg::NEIGHBORS];
    logic [etxnps_pkg::NEIGHBORS-1:0] present_reg;

    // Write port.
    logic          wr_link, wr_rank, wr_cnt, wr_pres;
    logic [TW-1:0] wr_addr;
    logic [15:0]   wr_link_data, wr_rank_data;
    logic [7:0]    wr_cnt_data;
    logic          wr_pres_data;

    // Read port with registered data.
    logic [TW-1:0] rd_addr;
    logic          rd_issue;
    logic [15:0]   rd_link_reg, rd_rank_reg;
    logic [7:0]    rd_cnt_reg;
    logic          rd_pres_reg;
    logic [TW-1:0] rd_idx_reg;
    logic          rd_tag_reg, rd_last_reg;

    etxnps_pkg::job_t job_reg, job_next;

    // Report arithmetic pipeline.
    logic [6:0]  weight_reg, weight_next;
    logic [15:0] pkt_reg, pkt_next;
    logic [15:0] old_etx_reg, old_etx_next;
    logic [15:0] hold_rank_reg, hold_rank_next;
    logic [7:0]  hold_cnt_reg, hold_cnt_next;
    logic [23:0] sum_reg, sum_next;
    logic [47:0] prod_reg, prod_next;

    // Scan state.
    logic [TW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          issued_all_reg, issued_all_next;
    logic          best_found_reg, best_found_next;
    logic [TW-1:0] best_idx_reg, best_idx_next;
    logic [15:0]   best_etx_reg, best_etx_next;
    logic [15:0]   best_rank_reg, best_rank_next;
    logic [TW-1:0] chosen_idx_reg, chosen_idx_next;
    logic [15:0]   chosen_etx_reg, chosen_etx_next;
    logic [15:0]   chosen_rank_reg, chosen_rank_next;

    etxnps_pkg::out_item_t res_reg, res_next;
    etxnps_pkg::out_item_t out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [6:0]  w_norm, w_early, w_inv;
    logic [4:0]  tx_mult;
    logic [15:0] quot;
    logic        candidate;
    logic [16:0] link_limit;

    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign w_norm    = clamp_weight(cfg.normal_weight);
    assign w_early   = clamp_weight(cfg.early_weight);
    assign w_inv     = etxnps_pkg::ETX_SCALE - weight_reg;
    assign tx_mult   = job_reg.noack ? cfg.noack_penalty : job_reg.attempts;
    assign quot      = prod_reg[RECIP_SHIFT_LO +: 16];
    assign candidate = rd_tag_reg && rd_pres_reg && (rd_rank_reg != etxnps_pkg::INFINITE_RANK);
    assign link_limit = {1'b0, best_etx_reg} + {1'b0, cfg.link_threshold};

    localparam int RECIP_SHIFT_LO = etxnps_pkg::RECIP_SHIFT;

    always_comb begin
        state_next       = state_reg;
        job_next         = job_reg;
        q_pop            = 1'b0;
        rd_addr          = TW'(job_reg.entry_index);
        rd_issue         = 1'b0;
        wr_link          = 1'b0;
        wr_rank          = 1'b0;
        wr_cnt           = 1'b0;
        wr_pres          = 1'b0;
        wr_addr          = TW'(job_reg.entry_index);
        wr_link_data     = job_reg.new_link_etx;
        wr_rank_data     = job_reg.new_rank;
        wr_cnt_data      = 8'd0;
        wr_pres_data     = job_reg.new_valid;
        weight_next      = weight_reg;
        pkt_next         = pkt_reg;
        old_etx_next     = old_etx_reg;
        hold_rank_next   = hold_rank_reg;
        hold_cnt_next    = hold_cnt_reg;
        sum_next         = sum_reg;
        prod_next        = prod_reg;
        scan_cnt_next    = scan_cnt_reg;
        issued_all_next  = issued_all_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_etx_next    = best_etx_reg;
        best_rank_next   = best_rank_reg;
        chosen_idx_next  = chosen_idx_reg;
        chosen_etx_next  = chosen_etx_reg;
        chosen_rank_next = chosen_rank_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                rd_addr = TW'(q_head.entry_index);
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    res_next = '0;
                    case (q_head.kind)
                        etxnps_pkg::KIND_REPORT: begin
                            state_next = ST_WEIGH;
                        end
                        etxnps_pkg::KIND_IGNORE: begin
                            res_next.parent_index = q_head.entry_index;
                            state_next            = ST_DONE;
                        end
                        etxnps_pkg::KIND_WRITE: begin
                            wr_addr      = TW'(q_head.entry_index);
                            wr_link_data = q_head.new_link_etx;
                            wr_rank_data = q_head.new_rank;
                            wr_pres_data = q_head.new_valid;
                            wr_link      = q_head.in_table;
                            wr_rank      = q_head.in_table;
                            wr_cnt       = q_head.in_table;
                            wr_pres      = q_head.in_table;
                            res_next.parent_index = q_head.entry_index;
                            res_next.link_etx_out = q_head.new_link_etx;
                            res_next.rank_out     = q_head.new_rank;
                            state_next            = ST_DONE;
                        end
                        etxnps_pkg::KIND_SELECT: begin
                            scan_cnt_next   = '0;
                            issued_all_next = 1'b0;
                            best_found_next = 1'b0;
                            state_next      = ST_SCAN1;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WEIGH: begin
                if (!rd_pres_reg) begin
                    res_next.parent_index = job_reg.entry_index;
                    state_next            = ST_DONE;
                end else begin
                    // Young entries take the smaller of the two weights.
                    if ((rd_cnt_reg < cfg.early_report_limit) && (w_early < w_norm)) begin
                        weight_next = w_early;
                    end else begin
                        weight_next = w_norm;
                    end
                    pkt_next       = 16'({11'd0, tx_mult} * {5'd0, cfg.etx_unit});
                    old_etx_next   = rd_link_reg;
                    hold_rank_next = rd_rank_reg;
                    hold_cnt_next  = rd_cnt_reg;
                    state_next     = ST_BLEND;
                end
            end

            ST_BLEND: begin
                sum_next = 24'({8'd0, old_etx_reg} * {17'd0, weight_reg})
                         + 24'({8'd0, pkt_reg} * {17'd0, w_inv});
                state_next = ST_SCALE;
            end

            ST_SCALE: begin
                prod_next  = {24'd0, sum_reg} * {24'd0, etxnps_pkg::RECIP_100};
                state_next = ST_STORE;
            end

            ST_STORE: begin
                wr_link      = 1'b1;
                wr_cnt       = 1'b1;
                wr_link_data = quot;
                wr_cnt_data  = (hold_cnt_reg == 8'hFF) ? 8'hFF : hold_cnt_reg + 8'd1;
                res_next.found        = 1'b1;
                res_next.parent_index = job_reg.entry_index;
                res_next.link_etx_out = quot;
                res_next.rank_out     = hold_rank_reg;
                state_next            = ST_DONE;
            end

            ST_SCAN1: begin
                rd_addr  = scan_cnt_reg;
                rd_issue = !issued_all_reg;
                if (!issued_all_reg) begin
                    if (scan_cnt_reg == LAST_ENTRY) begin
                        issued_all_next = 1'b1;
                        scan_cnt_next   = '0;
                    end else begin
                        scan_cnt_next = scan_cnt_reg + 1'b1;
                    end
                end
                if (candidate && (!best_found_reg || (rd_link_reg < best_etx_reg))) begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_etx_next   = rd_link_reg;
                    best_rank_next  = rd_rank_reg;
                end
                if (rd_tag_reg && rd_last_reg) begin
                    issued_all_next  = 1'b0;
                    chosen_idx_next  = best_idx_next;
                    chosen_etx_next  = best_etx_next;
                    chosen_rank_next = best_rank_next;
                    if (best_found_next) begin
                        state_next = ST_SCAN2;
                    end else begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN2: begin
                rd_addr  = scan_cnt_reg;
                rd_issue = !issued_all_reg;
                if (!issued_all_reg) begin
                    if (scan_cnt_reg == LAST_ENTRY) begin
                        issued_all_next = 1'b1;
                        scan_cnt_next   = '0;
                    end else begin
                        scan_cnt_next = scan_cnt_reg + 1'b1;
                    end
                end
                if (candidate && ({1'b0, rd_link_reg} < link_limit)
                        && (rd_rank_reg < chosen_rank_reg)) begin
                    chosen_idx_next  = rd_idx_reg;
                    chosen_etx_next  = rd_link_reg;
                    chosen_rank_next = rd_rank_reg;
                end
                if (rd_tag_reg && rd_last_reg) begin
                    issued_all_next       = 1'b0;
                    res_next.found        = 1'b1;
                    res_next.parent_index = 4'(chosen_idx_next);
                    res_next.link_etx_out = chosen_etx_next;
                    res_next.rank_out     = chosen_rank_next;
                    state_next            = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            present_reg    <= '0;
            rd_tag_reg     <= 1'b0;
            issued_all_reg <= 1'b0;
            scan_cnt_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            rd_tag_reg     <= rd_issue;
            issued_all_reg <= issued_all_next;
            scan_cnt_reg   <= scan_cnt_next;
            if (wr_pres) begin
                present_reg[wr_addr] <= wr_pres_data;
            end
        end
    end

    // Table memory: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (wr_link) begin
            link_mem[wr_addr] <= wr_link_data;
        end
        if (wr_rank) begin
            rank_mem[wr_addr] <= wr_rank_data;
        end
        if (wr_cnt) begin
            cnt_mem[wr_addr] <= wr_cnt_data;
        end
        rd_link_reg <= link_mem[rd_addr];
        rd_rank_reg <= rank_mem[rd_addr];
        rd_cnt_reg  <= cnt_mem[rd_addr];
        rd_pres_reg <= present_reg[rd_addr];
        rd_idx_reg  <= rd_addr;
        rd_last_reg <= (rd_addr == LAST_ENTRY);
    end

    always_ff @(posedge aclk) begin
        job_reg         <= job_next;
        weight_reg      <= weight_next;
        pkt_reg         <= pkt_next;
        old_etx_reg     <= old_etx_next;
        hold_rank_reg   <= hold_rank_next;
        hold_cnt_reg    <= hold_cnt_next;
        sum_reg         <= sum_next;
        prod_reg        <= prod_next;
        best_found_reg  <= best_found_next;
        best_idx_reg    <= best_idx_next;
        best_etx_reg    <= best_etx_next;
        best_rank_reg   <= best_rank_next;
        chosen_idx_reg  <= chosen_idx_next;
        chosen_etx_reg  <= chosen_etx_next;
        chosen_rank_reg <= chosen_rank_next;
        res_reg         <= res_next;
        out_reg         <= out_next;
    end

endmodule

`default_nettype wire

// ===== design/etxnps_checker.sv =====
// Port-level checker for the neighbour table block, bound to the top level.
// Depends on etxnps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "etx_neighbor_parent_select_assert.svh"

module etxnps_checker (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    input  wire                   s_ready,
    input  etxnps_pkg::in_item_t  s_data,
    input  wire                   m_valid,
    input  wire                   m_ready,
    input  etxnps_pkg::out_item_t m_data,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [4:0]            paddr,
    input  wire  [31:0]           pwdata,
    input  wire  [31:0]           prdata,
    input  wire                   pready
);

    // Items taken in and not yet delivered: queue, engine and result register.
    logic [2:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc       = s_valid && s_ready;
    assign out_acc      = m_valid && m_ready;
    assign pending_next = pending_reg + 3'(in_acc) - 3'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `ETXNPS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `ETXNPS_ASSERT_IMPL(a_result_has_item, m_valid, pending_reg != 3'd0)
    `ETXNPS_ASSERT_IMPL(a_capacity, s_valid || !s_valid, pending_reg <= 3'(etxnps_pkg::QUEUE_DEPTH + 2))
    `ETXNPS_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && (paddr[4:2] == etxnps_pkg::REG_LINK_THRESHOLD), (paddr != $past(paddr)) || (prdata == {16'd0, $past(pwdata[15:0])}))

endmodule

bind etx_neighbor_parent_select etxnps_checker u_checker (.*);

`default_nettype wire
